@@ rtl/mec_pkg.sv @@
package mec_pkg;

  localparam int COORD_BITS = 12;
  localparam int CMAX       = (1 << COORD_BITS) - 1;
  localparam int BTN_STRIDE = 6;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  typedef enum logic [1:0] {
    BTN_LEFT   = 2'd0,
    BTN_RIGHT  = 2'd1,
    BTN_MIDDLE = 2'd2
  } btn_t;

  typedef enum logic [4:0] {
    EV_NONE    = 5'd0,
    EV_MOVE    = 5'd1,
    EV_PRESS   = 5'd2,
    EV_RELEASE = 5'd3,
    EV_DCLICK  = 5'd4,
    EV_HOLD    = 5'd5,
    EV_DRAG    = 5'd6,
    EV_REPEAT  = 5'd7
  } ev_t;

  localparam logic [4:0] EV_CODE_MAX = 5'd19;

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_LEFT_HANDED = 3'd1,
    REG_ROWS        = 3'd2,
    REG_COLS        = 3'd3,
    REG_DCLICK      = 3'd4,
    REG_REP_START   = 3'd5,
    REG_REP         = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]         button_bits;
    logic signed [15:0] raw_row;
    logic signed [15:0] raw_col;
    logic [31:0]        now_tick;
  } sample_t;

  typedef struct packed {
    logic [4:0]            event_code;
    logic [COORD_BITS-1:0] cur_row;
    logic [COORD_BITS-1:0] cur_col;
  } result_t;

  typedef struct packed {
    logic        mouse_enable;
    logic        left_handed;
    logic [12:0] screen_rows;
    logic [12:0] screen_cols;
    logic [15:0] dclick_ticks;
    logic [15:0] repeat_start_ticks;
    logic [15:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]            prev_buttons;
    logic [COORD_BITS-1:0] prev_row;
    logic [COORD_BITS-1:0] prev_col;
    btn_t                  last_pressed;
    logic                  last_pressed_valid;
    logic [31:0]           event_time;
    logic                  repeat_active;
  } state_t;

  function automatic btn_t decode_button(input logic [2:0] bits);
    btn_t b;
    case (bits)
      3'b001:  b = BTN_LEFT;
      3'b010:  b = BTN_RIGHT;
      default: b = BTN_MIDDLE;
    endcase
    return b;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [15:0] raw,
                                                         input logic [12:0] count);
    logic [16:0]           top;
    logic [COORD_BITS-1:0] res;
    top = (count == 13'd0) ? 17'd0 : {4'd0, count} - 17'd1;
    if (top > 17'(CMAX)) top = 17'(CMAX);
    if (raw[15]) res = '0;
    else if ({2'd0, raw[14:0]} > top) res = COORD_BITS'(top);
    else res = COORD_BITS'(raw[14:0]);
    return res;
  endfunction

  function automatic logic [4:0] map_event(input ev_t ev, input btn_t btn, input logic swap);
    btn_t       b;
    logic [4:0] code;
    b = btn;
    if (swap) begin
      if (btn == BTN_LEFT) b = BTN_RIGHT;
      else if (btn == BTN_RIGHT) b = BTN_LEFT;
    end
    if (ev < EV_PRESS) begin
      code = ev;
    end else begin
      case (b)
        BTN_LEFT:  code = ev;
        BTN_RIGHT: code = ev + 5'(BTN_STRIDE);
        default:   code = ev + 5'(2 * BTN_STRIDE);
      endcase
    end
    return code;
  endfunction

endpackage

@@ rtl/mec_cfg.sv @@
module mec_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mec_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mec_pkg::DATA_BITS-1:0] pwdata,
  output logic [mec_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  output mec_pkg::cfg_t                 cfg
);
  import mec_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mouse_enable       <= 1'b1;
      cfg.left_handed        <= 1'b0;
      cfg.screen_rows        <= 13'd25;
      cfg.screen_cols        <= 13'd80;
      cfg.dclick_ticks       <= 16'd5;
      cfg.repeat_start_ticks <= 16'd10;
      cfg.repeat_ticks       <= 16'd2;
    end else if (wr) begin
      case (idx)
        REG_ENABLE:      cfg.mouse_enable       <= pwdata[0];
        REG_LEFT_HANDED: cfg.left_handed        <= pwdata[0];
        REG_ROWS:        cfg.screen_rows        <= pwdata[12:0];
        REG_COLS:        cfg.screen_cols        <= pwdata[12:0];
        REG_DCLICK:      cfg.dclick_ticks       <= pwdata[15:0];
        REG_REP_START:   cfg.repeat_start_ticks <= pwdata[15:0];
        REG_REP:         cfg.repeat_ticks       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:      prdata = {31'd0, cfg.mouse_enable};
      REG_LEFT_HANDED: prdata = {31'd0, cfg.left_handed};
      REG_ROWS:        prdata = {19'd0, cfg.screen_rows};
      REG_COLS:        prdata = {19'd0, cfg.screen_cols};
      REG_DCLICK:      prdata = {16'd0, cfg.dclick_ticks};
      REG_REP_START:   prdata = {16'd0, cfg.repeat_start_ticks};
      REG_REP:         prdata = {16'd0, cfg.repeat_ticks};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/mec_classify.sv @@
module mec_classify (
  input  mec_pkg::cfg_t    cfg,
  input  mec_pkg::state_t  st,
  input  mec_pkg::sample_t item,
  output mec_pkg::state_t  st_next,
  output mec_pkg::result_t res
);
  import mec_pkg::*;

  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] col;
  logic [2:0]            diff;
  logic [31:0]           elapsed;
  btn_t                  changed_btn;
  btn_t                  status_btn;
  btn_t                  btn;
  ev_t                   ev;

  assign row         = clamp_coord(item.raw_row, cfg.screen_rows);
  assign col         = clamp_coord(item.raw_col, cfg.screen_cols);
  assign diff        = item.button_bits ^ st.prev_buttons;
  assign elapsed     = item.now_tick - st.event_time;
  assign changed_btn = decode_button(diff);
  assign status_btn  = decode_button(item.button_bits);

  always_comb begin
    st_next = st;
    ev      = EV_NONE;
    btn     = BTN_LEFT;
    if (!cfg.mouse_enable) begin
      res.event_code = EV_NONE;
      res.cur_row    = st.prev_row;
      res.cur_col    = st.prev_col;
    end else begin
      if (row != st.prev_row || col != st.prev_col) begin
        st_next.last_pressed_valid = 1'b0;
        if (|st.prev_buttons) begin
          btn = status_btn;
          ev  = EV_DRAG;
        end else begin
          ev = EV_MOVE;
        end
      end else if (|diff) begin
        if ((diff & item.button_bits) == diff) begin
          if (st.last_pressed_valid && changed_btn == st.last_pressed &&
              elapsed < {16'd0, cfg.dclick_ticks}) begin
            ev = EV_DCLICK;
          end else begin
            ev = EV_PRESS;
            st_next.last_pressed       = changed_btn;
            st_next.last_pressed_valid = 1'b1;
          end
        end else begin
          ev = EV_RELEASE;
        end
        btn                   = changed_btn;
        st_next.prev_buttons  = item.button_bits;
        st_next.repeat_active = 1'b0;
        st_next.event_time    = item.now_tick;
      end else if (|item.button_bits) begin
        btn = status_btn;
        if (!st.repeat_active) begin
          if (elapsed > {16'd0, cfg.repeat_start_ticks}) begin
            ev                    = EV_REPEAT;
            st_next.repeat_active = 1'b1;
            st_next.event_time    = item.now_tick;
          end
        end else if (elapsed > {16'd0, cfg.repeat_ticks}) begin
          ev                 = EV_REPEAT;
          st_next.event_time = item.now_tick;
        end
      end
      st_next.prev_row = row;
      st_next.prev_col = col;
      res.event_code   = map_event(ev, btn, cfg.left_handed);
      res.cur_row      = row;
      res.cur_col      = col;
    end
  end

endmodule

@@ rtl/mouse_event_classifier_core.sv @@
// the input register and the result register form a two-stage pipeline; a sample
// in the input register moves to the result register unless result_stall holds
// it full; one sample per cycle otherwise. The event state updates with the result.
// reset: rst empties both stages, resets the event state and loads register defaults
module mouse_event_classifier_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  mec_pkg::sample_t              sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output mec_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mec_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mec_pkg::DATA_BITS-1:0] pwdata,
  output logic [mec_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import mec_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  sample_t in_q;
  logic    in_valid_q;
  result_t res_next;
  logic    adv;
  logic    fire;

  mec_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mec_classify u_classify (
    .cfg     (cfg),
    .st      (st),
    .item    (in_q),
    .st_next (st_next),
    .res     (res_next)
  );

  assign adv          = !result_valid || !result_stall;
  assign fire         = in_valid_q && adv;
  assign sample_stall = in_valid_q && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!sample_stall) begin
      in_valid_q <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      in_q <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev_buttons       <= '0;
      st.prev_row           <= '0;
      st.prev_col           <= '0;
      st.last_pressed       <= BTN_LEFT;
      st.last_pressed_valid <= 1'b1;
      st.event_time         <= '0;
      st.repeat_active      <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.event_code <= EV_CODE_MAX &&
                      result.event_code != EV_HOLD &&
                      result.event_code != 5'(EV_HOLD) + 5'(BTN_STRIDE) &&
                      result.event_code != 5'(EV_HOLD) + 5'(2 * BTN_STRIDE)))
    else $error("event code out of range");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(st))
    else $error("event state changed without an item");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (in_valid_q && result_valid && result_stall))
    else $error("stall without a full pipeline");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("item lost between stages");

endmodule

@@ test/mec_event_checker.sv @@
`timescale 1ns / 1ps

module mec_event_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  input  logic                          sample_stall,
  input  mec_pkg::sample_t              sample,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  mec_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [mec_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mec_pkg::DATA_BITS-1:0] pwdata,
  output int                            fail_count,
  output int                            pending
);
  import mec_pkg::*;

  logic        en;
  logic        swap;
  logic [12:0] rows;
  logic [12:0] cols;
  logic [15:0] dclick_win;
  logic [15:0] rep_first;
  logic [15:0] rep_next;

  logic [2:0]            held;
  logic [COORD_BITS-1:0] last_row;
  logic [COORD_BITS-1:0] last_col;
  btn_t                  last_btn;
  logic                  last_btn_ok;
  logic [31:0]           stamp;
  logic                  repeating;

  result_t expected_events[$];
  result_t want;

  task automatic report(input string what, input int got, input int exp_val);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    fail_count++;
  endtask

  function automatic btn_t pick_button(input logic [2:0] bits);
    btn_t b;
    if (bits == 3'b001) b = BTN_LEFT;
    else if (bits == 3'b010) b = BTN_RIGHT;
    else b = BTN_MIDDLE;
    return b;
  endfunction

  function automatic logic [COORD_BITS-1:0] clip(input logic signed [15:0] raw,
                                                 input logic [12:0] count);
    int v;
    int lim;
    v = raw;
    lim = (count == 13'd0) ? 0 : int'(count) - 1;
    if (lim > CMAX) lim = CMAX;
    if (v < 0) return '0;
    if (v > lim) return COORD_BITS'(lim);
    return COORD_BITS'(v);
  endfunction

  function automatic logic [4:0] code_for(input ev_t ev, input btn_t b);
    btn_t eff;
    eff = b;
    if (swap && b == BTN_LEFT) eff = BTN_RIGHT;
    else if (swap && b == BTN_RIGHT) eff = BTN_LEFT;
    if (ev == EV_NONE || ev == EV_MOVE) return 5'(ev);
    return 5'(ev) + 5'(BTN_STRIDE * int'(eff));
  endfunction

  function automatic result_t classify_sample(input sample_t s);
    result_t               r;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [2:0]            chg;
    logic [31:0]           span;
    ev_t                   ev;
    btn_t                  b;
    if (!en) begin
      r.event_code = 5'(EV_NONE);
      r.cur_row = last_row;
      r.cur_col = last_col;
      return r;
    end
    row = clip(s.raw_row, rows);
    col = clip(s.raw_col, cols);
    chg = s.button_bits ^ held;
    span = s.now_tick - stamp;
    ev = EV_NONE;
    b = BTN_LEFT;
    if (row != last_row || col != last_col) begin
      last_btn_ok = 1'b0;
      if (held != 3'b000) begin
        b = pick_button(s.button_bits);
        ev = EV_DRAG;
      end else begin
        ev = EV_MOVE;
      end
    end else if (chg != 3'b000) begin
      b = pick_button(chg);
      if ((chg & s.button_bits) == chg) begin
        if (last_btn_ok && b == last_btn && span < {16'd0, dclick_win}) begin
          ev = EV_DCLICK;
        end else begin
          ev = EV_PRESS;
          last_btn = b;
          last_btn_ok = 1'b1;
        end
      end else begin
        ev = EV_RELEASE;
      end
      held = s.button_bits;
      repeating = 1'b0;
      stamp = s.now_tick;
    end else if (s.button_bits != 3'b000) begin
      b = pick_button(s.button_bits);
      if (!repeating) begin
        if (span > {16'd0, rep_first}) begin
          ev = EV_REPEAT;
          repeating = 1'b1;
          stamp = s.now_tick;
        end
      end else if (span > {16'd0, rep_next}) begin
        ev = EV_REPEAT;
        stamp = s.now_tick;
      end
    end
    last_row = row;
    last_col = col;
    r.event_code = code_for(ev, b);
    r.cur_row = row;
    r.cur_col = col;
    return r;
  endfunction

  function automatic void write_reg(input logic [2:0] idx, input logic [31:0] v);
    case (reg_idx_t'(idx))
      REG_ENABLE:      en = v[0];
      REG_LEFT_HANDED: swap = v[0];
      REG_ROWS:        rows = v[12:0];
      REG_COLS:        cols = v[12:0];
      REG_DCLICK:      dclick_win = v[15:0];
      REG_REP_START:   rep_first = v[15:0];
      REG_REP:         rep_next = v[15:0];
      default: ;
    endcase
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      en = 1'b1;
      swap = 1'b0;
      rows = 13'd25;
      cols = 13'd80;
      dclick_win = 16'd5;
      rep_first = 16'd10;
      rep_next = 16'd2;
      held = 3'b000;
      last_row = '0;
      last_col = '0;
      last_btn = BTN_LEFT;
      last_btn_ok = 1'b1;
      stamp = 32'd0;
      repeating = 1'b0;
      expected_events.delete();
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[4:2], pwdata);
      if (result_valid && !result_stall) begin
        if (expected_events.size() == 0) begin
          report("unexpected result item", int'(result.event_code), -1);
        end else begin
          want = expected_events.pop_front();
          if (result.event_code !== want.event_code)
            report("event_code", int'(result.event_code), int'(want.event_code));
          if (result.cur_row !== want.cur_row)
            report("cur_row", int'(result.cur_row), int'(want.cur_row));
          if (result.cur_col !== want.cur_col)
            report("cur_col", int'(result.cur_col), int'(want.cur_col));
        end
      end
      if (sample_valid && !sample_stall) expected_events.push_back(classify_sample(sample));
    end
    pending <= expected_events.size();
  end

endmodule

@@ test/mouse_event_classifier_core_tb.sv @@
`timescale 1ns / 1ps

module mouse_event_classifier_core_tb;
  import mec_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 sample_valid;
  logic                 sample_stall;
  sample_t              sample;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  int fail_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  logic signed [15:0] pos_row;
  logic signed [15:0] pos_col;
  logic [2:0]         btns;
  logic [31:0]        tick;

  mouse_event_classifier_core u_top (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  mec_event_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, or a long hold-off while hold_left runs down
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic sample_t mk(input logic [2:0] b, input int r, input int c,
                                 input logic [31:0] t);
    sample_t s;
    s.button_bits = b;
    s.raw_row = 16'(r);
    s.raw_col = 16'(c);
    s.now_tick = t;
    return s;
  endfunction

  function automatic sample_t next_sample();
    int      pick;
    sample_t s;
    pick = $urandom_range(99);
    if (pick < 12) begin
      if ($urandom_range(3) == 0) pos_row = 16'($urandom);
      else pos_row = 16'($urandom_range(0, 30));
      if ($urandom_range(3) == 0) pos_col = 16'($urandom);
      else pos_col = 16'($urandom_range(0, 90));
    end
    pick = $urandom_range(99);
    if (pick < 45) btns = btns;
    else if (pick < 70) btns = btns ^ (3'b001 << $urandom_range(2));
    else if (pick < 85) btns = ($urandom_range(3) == 0) ? 3'b000 : 3'b001 << $urandom_range(2);
    else btns = 3'($urandom);
    pick = $urandom_range(99);
    if (pick < 80) tick = tick + $urandom_range(0, 8);
    else if (pick < 95) tick = tick + $urandom_range(0, 80);
    else tick = $urandom;
    s.button_bits = btns;
    s.raw_row = pos_row;
    s.raw_col = pos_col;
    s.now_tick = tick;
    return s;
  endfunction

  task automatic send(input sample_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic wait_quiet();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_cfg(input int e, input int lh, input int r, input int c,
                           input int dc, input int rs, input int rp);
    cfg_write(REG_ENABLE, 32'(e));
    cfg_write(REG_LEFT_HANDED, 32'(lh));
    cfg_write(REG_ROWS, 32'(r));
    cfg_write(REG_COLS, 32'(c));
    cfg_write(REG_DCLICK, 32'(dc));
    cfg_write(REG_REP_START, 32'(rs));
    cfg_write(REG_REP, 32'(rp));
  endtask

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pos_row = '0;
    pos_col = '0;
    btns = 3'b000;
    tick = 32'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: double-click right after reset, repeats, drags, clamping, tick wrap
    send(mk(3'b000, 0, 0, 32'd0));
    send(mk(3'b001, 0, 0, 32'd1));
    send(mk(3'b000, 0, 0, 32'd2));
    send(mk(3'b001, 0, 0, 32'd9));
    send(mk(3'b000, 0, 0, 32'd10));
    send(mk(3'b001, 0, 0, 32'd12));
    send(mk(3'b001, 0, 0, 32'd30));
    send(mk(3'b001, 0, 0, 32'd31));
    send(mk(3'b001, 0, 0, 32'd35));
    send(mk(3'b001, 5, 7, 32'd36));
    send(mk(3'b011, 5, 7, 32'd37));
    send(mk(3'b010, 5, 7, 32'd38));
    send(mk(3'b000, 5, 7, 32'd39));
    send(mk(3'b100, 5, 7, 32'd40));
    send(mk(3'b100, -1, -32768, 32'd41));
    send(mk(3'b000, 32767, 32767, 32'd42));
    send(mk(3'b000, 32767, 32767, 32'd43));
    send(mk(3'b111, 32767, 32767, 32'hFFFF_FFF0));
    send(mk(3'b111, 32767, 32767, 32'h0000_0005));
    send(mk(3'b101, 24, 79, 32'h0000_0006));
    send(mk(3'b000, 24, 79, 32'hFFFF_FFFF));

    for (int ph = 0; ph < 6; ph++) begin
      wait_quiet();
      case (ph)
        0: apply_cfg(1, 0, 25, 80, 5, 10, 2);
        1: apply_cfg(1, 1, 4096, 4096, 65535, 0, 0);
        2: apply_cfg(1, 0, 1, 1, 0, 65535, 65535);
        3: apply_cfg(1, 1, 0, 8191, 20, 3, 1);
        4: apply_cfg(0, 0, 25, 80, 5, 10, 2);
        default: apply_cfg(1, $urandom_range(1), $urandom_range(1, 60),
                           $urandom_range(1, 200), $urandom_range(0, 30),
                           $urandom_range(0, 20), $urandom_range(0, 6));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 80; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 80; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      if (ph == 0) hold_left = 80;
      repeat ((ph == 4) ? 60 : 220) send(next_sample());
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
